// ===== rtl/core/mbrps_pkg.sv =====
`default_nettype none

package mbrps_pkg;

    localparam int POOL_SLOTS    = 16;
    localparam int TABLE_ENTRIES = 4;
    localparam int SLOT_W        = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int ENTRY_W       = $clog2(TABLE_ENTRIES);

    localparam logic [8:0]  TABLE_AT   = 9'd446;
    localparam logic [8:0]  TABLE_END  = 9'd510;
    localparam logic [8:0]  SIG_AT     = 9'd510;
    localparam logic [8:0]  LAST_AT    = 9'd511;
    localparam logic [15:0] SIG_WORD   = 16'hAA55;
    localparam logic [15:0] MIN_SECTOR = 16'd512;

    localparam logic KIND_PART  = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SIG    = 2'd1,
        ST_TOO_SMALL = 2'd2,
        ST_POOL_FULL = 2'd3
    } t_scan_status;

    typedef enum logic [1:0] {
        S_STREAM,
        S_ENTRY,
        S_CLOSE
    } t_state;

    typedef struct packed {
        logic take;        // input transaction accepted
        logic start_scan;  // byte 511 accepted, latch header status
        logic load_part;   // load a partition record and claim a slot
        logic load_close;  // load the closing record
        logic set_full;    // no free slot for the current entry
        logic next_entry;  // step to the next table entry
    } t_cmd;

    typedef struct packed {
        logic last_byte;   // incoming byte sits at offset 511
        logic hdr_bad;     // sector too small or signature mismatch
        logic ent_ok;      // current entry has nonzero type and count
        logic slot_avail;  // at least one pool slot is free
        logic out_free;    // output register can take a record this cycle
        logic entry_last;  // current entry is the last table entry
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/core/mbr_partition_scanner.sv =====
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: data_byte; tuser: first_byte
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: record fields; tuser: kind;
//                                                     tlast: closing record
// cfg       in         i_cfg_we                       i_cfg_wdata: device sector size
//
// Sector bytes are taken at one per cycle except during the entry walk. After byte 511
// the input stalls while the walk visits the table entries in turn (none when the header
// check fails; it stops early when the pool is full) and then loads the closing record;
// output backpressure extends the walk.
// The closing record sits in the output register while the next sector streams in.
// Reset is synchronous; the slot pool is freed only by reset.
`default_nettype none

module mbr_partition_scanner (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [15:0] i_cfg_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire  [0:0]  s_axis_tuser,   // [0] first_byte
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [87:0] m_axis_tdata,   // entry_number, slot_index, part_type, start sector,
                                        // sector total, scan_status, found_count, zero pad
    output logic [0:0]  m_axis_tuser,   // [0] record_kind
    output logic        m_axis_tlast    // last_result
);

    mbrps_pkg::t_cmd    cmd;
    mbrps_pkg::t_status status;

    logic        record_kind;
    logic [1:0]  entry_number;
    logic [3:0]  slot_index;
    logic [7:0]  part_type;
    logic [31:0] start_sector;
    logic [31:0] sector_total;
    logic [1:0]  scan_status;
    logic [2:0]  found_count;
    logic        last_result;

    mbrps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mbrps_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_data_byte    (s_axis_tdata),
        .i_first_byte   (s_axis_tuser[0]),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_record_kind  (record_kind),
        .o_entry_number (entry_number),
        .o_slot_index   (slot_index),
        .o_part_type    (part_type),
        .o_start_sector (start_sector),
        .o_sector_total (sector_total),
        .o_scan_status  (scan_status),
        .o_found_count  (found_count),
        .o_last_result  (last_result)
    );

    assign m_axis_tdata = {5'd0, found_count, scan_status, sector_total, start_sector,
                           part_type, slot_index, entry_number};
    assign m_axis_tuser = record_kind;
    assign m_axis_tlast = last_result;

endmodule

`default_nettype wire

// ===== rtl/core/mbrps_ctrl.sv =====
`default_nettype none

module mbrps_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire mbrps_pkg::t_status i_status,
    output mbrps_pkg::t_cmd        o_cmd
);

    mbrps_pkg::t_state r_state;
    mbrps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbrps_pkg::S_STREAM;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mbrps_pkg::S_STREAM: begin
                if (i_in_valid && i_status.last_byte) begin
                    n_state = i_status.hdr_bad ? mbrps_pkg::S_CLOSE : mbrps_pkg::S_ENTRY;
                end
            end
            mbrps_pkg::S_ENTRY: begin
                if (!i_status.ent_ok) begin
                    if (i_status.entry_last) begin
                        n_state = mbrps_pkg::S_CLOSE;
                    end
                end else if (!i_status.slot_avail) begin
                    n_state = mbrps_pkg::S_CLOSE;
                end else if (i_status.out_free && i_status.entry_last) begin
                    n_state = mbrps_pkg::S_CLOSE;
                end
            end
            mbrps_pkg::S_CLOSE: begin
                if (i_status.out_free) begin
                    n_state = mbrps_pkg::S_STREAM;
                end
            end
            default: n_state = mbrps_pkg::S_STREAM;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            mbrps_pkg::S_STREAM: begin
                o_in_ready       = 1'b1;
                o_cmd.take       = i_in_valid;
                o_cmd.start_scan = i_in_valid && i_status.last_byte;
            end
            mbrps_pkg::S_ENTRY: begin
                if (!i_status.ent_ok) begin
                    o_cmd.next_entry = 1'b1;
                end else if (!i_status.slot_avail) begin
                    o_cmd.set_full = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.load_part  = 1'b1;
                    o_cmd.next_entry = 1'b1;
                end
            end
            mbrps_pkg::S_CLOSE: begin
                o_cmd.load_close = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/mbrps_dpath.sv =====
`default_nettype none

module mbrps_dpath (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire  [15:0]            i_cfg_wdata,
    input  wire  [7:0]             i_data_byte,
    input  wire                    i_first_byte,
    input  wire mbrps_pkg::t_cmd   i_cmd,
    output mbrps_pkg::t_status     o_status,
    input  wire                    i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_record_kind,
    output logic [1:0]             o_entry_number,
    output logic [3:0]             o_slot_index,
    output logic [7:0]             o_part_type,
    output logic [31:0]            o_start_sector,
    output logic [31:0]            o_sector_total,
    output logic [1:0]             o_scan_status,
    output logic [2:0]             o_found_count,
    output logic                   o_last_result
);

    logic [15:0] r_blk_size;
    logic [8:0]  r_byte_count;
    logic [7:0]  r_sig_low;
    logic [mbrps_pkg::POOL_SLOTS-1:0] r_slot_used;

    logic [7:0]  r_type  [mbrps_pkg::TABLE_ENTRIES];
    logic [31:0] r_start [mbrps_pkg::TABLE_ENTRIES];
    logic [31:0] r_count [mbrps_pkg::TABLE_ENTRIES];

    logic [mbrps_pkg::ENTRY_W-1:0] r_entry;
    logic [2:0]                    r_found;
    mbrps_pkg::t_scan_status       r_status;

    logic        r_out_valid;
    logic        r_kind;
    logic [1:0]  r_o_entry;
    logic [3:0]  r_o_slot;
    logic [7:0]  r_o_type;
    logic [31:0] r_o_start;
    logic [31:0] r_o_count;
    logic [1:0]  r_o_status;
    logic [2:0]  r_o_found;
    logic        r_o_last;

    logic [8:0]  pos;
    logic [8:0]  rel_full;
    logic [5:0]  rel;
    logic        in_table;
    mbrps_pkg::t_scan_status hdr_status;
    logic [mbrps_pkg::POOL_SLOTS-1:0] free_bits;
    logic [mbrps_pkg::SLOT_W-1:0]     free_idx;
    logic                             out_free;

    assign pos      = i_first_byte ? 9'd0 : r_byte_count;
    assign rel_full = pos - mbrps_pkg::TABLE_AT;
    assign rel      = rel_full[5:0];
    assign in_table = (pos >= mbrps_pkg::TABLE_AT) && (pos < mbrps_pkg::TABLE_END);

    always_comb begin
        priority if (r_blk_size < mbrps_pkg::MIN_SECTOR) begin
            hdr_status = mbrps_pkg::ST_TOO_SMALL;
        end else if ({i_data_byte, r_sig_low} != mbrps_pkg::SIG_WORD) begin
            hdr_status = mbrps_pkg::ST_NO_SIG;
        end else begin
            hdr_status = mbrps_pkg::ST_OK;
        end
    end

    // Lowest free slot wins.
    assign free_bits = ~r_slot_used;
    always_comb begin
        free_idx = '0;
        for (int i = mbrps_pkg::POOL_SLOTS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                free_idx = mbrps_pkg::SLOT_W'(i);
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_status.last_byte  = (pos == mbrps_pkg::LAST_AT);
        o_status.hdr_bad    = (hdr_status != mbrps_pkg::ST_OK);
        o_status.ent_ok     = (r_type[r_entry] != 8'd0) && (r_count[r_entry] != 32'd0);
        o_status.slot_avail = |free_bits;
        o_status.out_free   = out_free;
        o_status.entry_last = (r_entry == mbrps_pkg::ENTRY_W'(mbrps_pkg::TABLE_ENTRIES - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_size    <= mbrps_pkg::MIN_SECTOR;
            r_byte_count  <= '0;
            r_sig_low     <= '0;
            r_slot_used   <= '0;
            r_out_valid   <= 1'b0;
            r_found       <= '0;
            r_entry       <= '0;
            r_status      <= mbrps_pkg::ST_OK;
        end else begin
            if (i_cfg_we) begin
                r_blk_size <= i_cfg_wdata;
            end
            if (i_cmd.take) begin
                r_byte_count <= pos + 9'd1;
                if (pos == mbrps_pkg::SIG_AT) begin
                    r_sig_low <= i_data_byte;
                end
            end
            if (i_cmd.start_scan) begin
                r_status <= hdr_status;
                r_found  <= '0;
                r_entry  <= '0;
            end
            if (i_cmd.set_full) begin
                r_status <= mbrps_pkg::ST_POOL_FULL;
            end
            if (i_cmd.next_entry) begin
                r_entry <= r_entry + 1'b1;
            end
            if (i_cmd.load_part) begin
                r_slot_used[free_idx] <= 1'b1;
                r_found               <= r_found + 3'd1;
            end
            if (i_cmd.load_part || i_cmd.load_close) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Partition table capture: type at offset 4, start at 8..11, count at 12..15.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && in_table) begin
            unique case (rel[3:2])
                2'b01: begin
                    if (rel[1:0] == 2'b00) begin
                        r_type[rel[5:4]] <= i_data_byte;
                    end
                end
                2'b10: r_start[rel[5:4]][{rel[1:0], 3'b000} +: 8] <= i_data_byte;
                2'b11: r_count[rel[5:4]][{rel[1:0], 3'b000} +: 8] <= i_data_byte;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_part) begin
            r_kind     <= mbrps_pkg::KIND_PART;
            r_o_entry  <= 2'(r_entry);
            r_o_slot   <= 4'(free_idx);
            r_o_type   <= r_type[r_entry];
            r_o_start  <= r_start[r_entry];
            r_o_count  <= r_count[r_entry];
            r_o_status <= mbrps_pkg::ST_OK;
            r_o_found  <= '0;
            r_o_last   <= 1'b0;
        end else if (i_cmd.load_close) begin
            r_kind     <= mbrps_pkg::KIND_CLOSE;
            r_o_entry  <= '0;
            r_o_slot   <= '0;
            r_o_type   <= '0;
            r_o_start  <= '0;
            r_o_count  <= '0;
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_last   <= 1'b1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_record_kind  = r_kind;
    assign o_entry_number = r_o_entry;
    assign o_slot_index   = r_o_slot;
    assign o_part_type    = r_o_type;
    assign o_start_sector = r_o_start;
    assign o_sector_total = r_o_count;
    assign o_scan_status  = r_o_status;
    assign o_found_count  = r_o_found;
    assign o_last_result  = r_o_last;

endmodule

`default_nettype wire

// ===== rtl/core/mbrps_checker.sv =====
`default_nettype none

module mbrps_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tready,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire  [87:0] m_axis_tdata,
    input wire  [0:0]  m_axis_tuser,
    input wire         m_axis_tlast
);

    // A stalled record must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output record changed while stalled");

    a_kind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] == m_axis_tlast))
        else $error("record kind and last flag disagree");

    a_found_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[82:80] <= 3'd4)
        else $error("found count above table size");

    // While a partition record is pending the scan is still running.
    a_scan_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> !s_axis_tready && m_axis_tdata[82:78] == 5'd0)
        else $error("input open or summary fields set during partition emission");

endmodule

bind mbr_partition_scanner mbrps_checker u_mbrps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== verif/mbr_partition_scanner_tb.sv =====
module mbr_partition_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 12;
    localparam int HOLD_CYCLES = 1500;
    localparam logic [3:0] OFF_TYPE  = 4'd4;
    localparam logic [3:0] OFF_START = 4'd8;
    localparam logic [3:0] OFF_COUNT = 4'd12;

    // Entry sets for the directed sectors, entry 3 in the top lane.
    localparam logic [3:0][7:0]  TYPES_ALL  = {8'h0C, 8'hFF, 8'h07, 8'h83};
    localparam logic [3:0][7:0]  TYPES_ODD  = {8'h05, 8'h00, 8'h0B, 8'h00};
    localparam logic [3:0][7:0]  TYPES_NONE = '0;
    localparam logic [3:0][31:0] STARTS_ALL = {32'h12345678, 32'h0, 32'hFFFFFFFF, 32'h800};
    localparam logic [3:0][31:0] COUNTS_ALL = {32'h80000000, 32'h1, 32'hFFFFFFFF, 32'h1F800};
    localparam logic [3:0][31:0] COUNTS_NONE = '0;

    typedef enum logic [1:0] {
        LEAD_FIRST,
        LEAD_WRAP,
        LEAD_STRAY
    } t_lead;

    typedef struct packed {
        logic                    kind;
        logic [1:0]              entry;
        logic [3:0]              slot;
        logic [7:0]              ptype;
        logic [31:0]             lba0;
        logic [31:0]             nsec;
        mbrps_pkg::t_scan_status st;
        logic [2:0]              found;
        logic                    last;
    } t_mbr_record;

    typedef struct packed {
        logic                    cfg_wr;
        logic [15:0]             cfg;
        logic [3:0][7:0]         types;
        logic [3:0][31:0]        starts;
        logic [3:0][31:0]        counts;
        logic [15:0]             sig;
        t_lead                   lead;
        logic                    typed;
        mbrps_pkg::t_scan_status st;
        logic [2:0]              found;
    } t_sector_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [15:0]  i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = '0;
    logic [0:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [87:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         m_axis_tlast;

    mbr_partition_scanner uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Scanner state as the testbench sees it.
    logic [15:0]      sector_bytes = mbrps_pkg::MIN_SECTOR;
    logic [8:0]       byte_pos = '0;
    logic [3:0][7:0]  tbl_type = '0;
    logic [3:0][31:0] tbl_start = '0;
    logic [3:0][31:0] tbl_count = '0;
    logic [7:0]       sig_lo = '0;
    logic [mbrps_pkg::POOL_SLOTS-1:0] slots_taken = '0;

    t_mbr_record pending_records[$];

    // A directed row may pin the closing record to typed-in values.
    logic                    close_fixed = 1'b0;
    mbrps_pkg::t_scan_status fixed_st = mbrps_pkg::ST_OK;
    logic [2:0]              fixed_found = '0;

    bit calm = 0;
    bit hold_req = 0;
    int mismatches = 0;
    int cycles = 0;
    int bytes_taken = 0;
    int records_predicted = 0;
    int parts_seen = 0;
    int closes_seen = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    task automatic compare_field(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
            mismatches++;
        end
    endtask

    // Runs the table walk that byte 511 starts and queues the records it yields.
    task automatic walk_partition_table(input logic [7:0] sig_hi);
        t_mbr_record rec;
        mbrps_pkg::t_scan_status st;
        logic [2:0] found;
        int slot;
        st = mbrps_pkg::ST_OK;
        found = '0;
        if (sector_bytes < mbrps_pkg::MIN_SECTOR) begin
            st = mbrps_pkg::ST_TOO_SMALL;
        end else if ({sig_hi, sig_lo} != mbrps_pkg::SIG_WORD) begin
            st = mbrps_pkg::ST_NO_SIG;
        end else begin
            for (int e = 0; e < mbrps_pkg::TABLE_ENTRIES; e++) begin
                if (tbl_type[e] != 8'd0 && tbl_count[e] != 32'd0) begin
                    slot = -1;
                    for (int i = mbrps_pkg::POOL_SLOTS - 1; i >= 0; i--) begin
                        if (!slots_taken[i]) begin
                            slot = i;
                        end
                    end
                    if (slot < 0) begin
                        st = mbrps_pkg::ST_POOL_FULL;
                        break;
                    end
                    slots_taken[slot] = 1'b1;
                    rec = '0;
                    rec.kind = mbrps_pkg::KIND_PART;
                    rec.entry = e[1:0];
                    rec.slot = slot[3:0];
                    rec.ptype = tbl_type[e];
                    rec.lba0 = tbl_start[e];
                    rec.nsec = tbl_count[e];
                    pending_records.push_back(rec);
                    records_predicted++;
                    found++;
                end
            end
        end
        rec = '0;
        rec.kind = mbrps_pkg::KIND_CLOSE;
        rec.st = close_fixed ? fixed_st : st;
        rec.found = close_fixed ? fixed_found : found;
        rec.last = 1'b1;
        close_fixed = 1'b0;
        pending_records.push_back(rec);
        records_predicted++;
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic first);
        logic [8:0] pos;
        logic [8:0] rel;
        logic [1:0] e;
        logic [3:0] off;
        pos = first ? 9'd0 : byte_pos;
        byte_pos = pos + 9'd1;
        if (pos >= mbrps_pkg::TABLE_AT && pos < mbrps_pkg::TABLE_END) begin
            rel = pos - mbrps_pkg::TABLE_AT;
            e = rel[5:4];
            off = rel[3:0];
            if (off == OFF_TYPE) begin
                tbl_type[e] = b;
            end else if (off >= OFF_START && off < OFF_COUNT) begin
                tbl_start[e][(off - OFF_START) * 8 +: 8] = b;
            end else if (off >= OFF_COUNT) begin
                tbl_count[e][(off - OFF_COUNT) * 8 +: 8] = b;
            end
        end
        if (pos == mbrps_pkg::SIG_AT) begin
            sig_lo = b;
        end else if (pos == mbrps_pkg::LAST_AT) begin
            walk_partition_table(b);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic first);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= first;
        do @(posedge i_clk); while (!s_axis_tready);
        absorb_byte(b, first);
        bytes_taken++;
        if (!calm && $urandom_range(0, 19) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic send_sector(input logic [3:0][7:0] types, input logic [3:0][31:0] starts,
                               input logic [3:0][31:0] counts, input logic [15:0] sig,
                               input t_lead lead);
        logic [7:0] img [0:511];
        int base;
        int cut;
        for (int i = 0; i < 512; i++) begin
            img[i] = 8'($urandom);
        end
        for (int e = 0; e < mbrps_pkg::TABLE_ENTRIES; e++) begin
            base = int'(mbrps_pkg::TABLE_AT) + 16 * e;
            img[base + 4] = types[e];
            for (int k = 0; k < 4; k++) begin
                img[base + 8 + k] = starts[e][8 * k +: 8];
                img[base + 12 + k] = counts[e][8 * k +: 8];
            end
        end
        img[510] = sig[7:0];
        img[511] = sig[15:8];
        // A stray restart drops a partial sector of garbage, 1 to 511 bytes long.
        if (lead == LEAD_STRAY) begin
            cut = $urandom_range(1, 511);
            for (int i = 0; i < cut; i++) begin
                send_byte(8'($urandom), i == 0);
            end
        end
        for (int i = 0; i < 512; i++) begin
            send_byte(img[i], lead != LEAD_WRAP && i == 0);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_sector_size(input logic [15:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sector_bytes = v;
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out with %0d records pending", pending_records.size());
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin : record_check
        t_mbr_record want;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            if (pending_records.size() == 0) begin
                compare_field("records pending", 32'd0, 32'd1);
            end else begin
                want = pending_records.pop_front();
                compare_field("record_kind", m_axis_tuser[0], want.kind);
                compare_field("entry_number", m_axis_tdata[1:0], want.entry);
                compare_field("slot_index", m_axis_tdata[5:2], want.slot);
                compare_field("part_type", m_axis_tdata[13:6], want.ptype);
                compare_field("start_sector", m_axis_tdata[45:14], want.lba0);
                compare_field("sector_total", m_axis_tdata[77:46], want.nsec);
                compare_field("scan_status", m_axis_tdata[79:78], want.st);
                compare_field("found_count", m_axis_tdata[82:80], want.found);
                compare_field("tdata pad", m_axis_tdata[87:83], 32'd0);
                compare_field("last_result", m_axis_tlast, want.last);
            end
            if (m_axis_tuser[0] == mbrps_pkg::KIND_CLOSE) begin
                closes_seen++;
                status_seen[m_axis_tdata[79:78]]++;
            end else begin
                parts_seen++;
            end
        end
    end

    // Output side: short random stalls, plus one long hold-off on request.
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        t_sector_row rows [0:12];
        logic [3:0][7:0]  ty;
        logic [3:0][31:0] lba0;
        logic [3:0][31:0] nsec;
        logic [15:0] sg;
        t_lead ld;
        int base_recs;
        int s;
        int r;
        bit at_boundary;

        rows[0]  = '{1'b0, 16'd0, TYPES_ALL, STARTS_ALL, COUNTS_ALL, 16'hAA55,
                     LEAD_FIRST, 1'b1, mbrps_pkg::ST_OK, 3'd4};
        rows[1]  = '{1'b0, 16'd0, TYPES_NONE, STARTS_ALL, COUNTS_ALL, 16'hAA55,
                     LEAD_FIRST, 1'b1, mbrps_pkg::ST_OK, 3'd0};
        rows[2]  = '{1'b0, 16'd0, TYPES_ALL, STARTS_ALL, COUNTS_NONE, 16'hAA55,
                     LEAD_FIRST, 1'b1, mbrps_pkg::ST_OK, 3'd0};
        rows[3]  = '{1'b0, 16'd0, TYPES_ALL, STARTS_ALL, COUNTS_ALL, 16'hAA54,
                     LEAD_FIRST, 1'b1, mbrps_pkg::ST_NO_SIG, 3'd0};
        rows[4]  = '{1'b0, 16'd0, TYPES_ALL, STARTS_ALL, COUNTS_ALL, 16'hAB55,
                     LEAD_FIRST, 1'b1, mbrps_pkg::ST_NO_SIG, 3'd0};
        rows[5]  = '{1'b1, 16'd511, TYPES_ALL, STARTS_ALL, COUNTS_ALL, 16'hAA55,
                     LEAD_FIRST, 1'b1, mbrps_pkg::ST_TOO_SMALL, 3'd0};
        rows[6]  = '{1'b1, 16'd0, TYPES_ALL, STARTS_ALL, COUNTS_ALL, 16'h0000,
                     LEAD_FIRST, 1'b1, mbrps_pkg::ST_TOO_SMALL, 3'd0};
        rows[7]  = '{1'b1, 16'hFFFF, TYPES_ODD, STARTS_ALL, COUNTS_ALL, 16'hAA55,
                     LEAD_WRAP, 1'b0, mbrps_pkg::ST_OK, 3'd0};
        rows[8]  = '{1'b0, 16'd0, TYPES_ALL, STARTS_ALL, COUNTS_ALL, 16'hAA55,
                     LEAD_STRAY, 1'b0, mbrps_pkg::ST_OK, 3'd0};
        rows[9]  = '{1'b1, 16'd512, TYPES_ALL, STARTS_ALL, COUNTS_ALL, 16'hAA55,
                     LEAD_FIRST, 1'b0, mbrps_pkg::ST_OK, 3'd0};
        // Fourteen slots are taken by now: two more fit, then the pool runs dry.
        rows[10] = '{1'b0, 16'd0, TYPES_ALL, STARTS_ALL, COUNTS_ALL, 16'hAA55,
                     LEAD_FIRST, 1'b1, mbrps_pkg::ST_POOL_FULL, 3'd2};
        rows[11] = '{1'b0, 16'd0, TYPES_ALL, STARTS_ALL, COUNTS_ALL, 16'hAA55,
                     LEAD_FIRST, 1'b1, mbrps_pkg::ST_POOL_FULL, 3'd0};
        rows[12] = '{1'b0, 16'd0, TYPES_NONE, STARTS_ALL, COUNTS_ALL, 16'hAA55,
                     LEAD_FIRST, 1'b1, mbrps_pkg::ST_OK, 3'd0};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].cfg_wr) begin
                write_sector_size(rows[i].cfg);
            end
            close_fixed = rows[i].typed;
            fixed_st = rows[i].st;
            fixed_found = rows[i].found;
            send_sector(rows[i].types, rows[i].starts, rows[i].counts, rows[i].sig,
                        rows[i].lead);
        end
        drain();

        base_recs = records_predicted;
        at_boundary = 1;
        s = 0;
        while (records_predicted - base_recs < 48) begin
            if (s == 2) begin
                hold_req = 1;
            end
            if (s == 5) begin
                drain();
            end
            if (s % 9 == 8) begin
                case ($urandom_range(0, 5))
                    0: write_sector_size(16'($urandom_range(0, 511)));
                    1: write_sector_size(16'hFFFF);
                    default: write_sector_size(16'($urandom_range(512, 65535)));
                endcase
            end
            if (records_predicted - base_recs >= 40) begin
                calm = 1;
            end
            // Noise between sectors: short runs of bytes with scattered restarts.
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 200)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
                at_boundary = 0;
            end
            for (int e = 0; e < mbrps_pkg::TABLE_ENTRIES; e++) begin
                ty[e] = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                lba0[e] = $urandom;
                case ($urandom_range(0, 4))
                    0: nsec[e] = 32'd0;
                    1: nsec[e] = 32'hFFFFFFFF;
                    default: nsec[e] = $urandom;
                endcase
            end
            sg = ($urandom_range(0, 6) == 0) ? 16'($urandom) : mbrps_pkg::SIG_WORD;
            r = $urandom_range(0, 19);
            if (r < 3) begin
                ld = LEAD_STRAY;
            end else if (r < 6 && at_boundary) begin
                ld = LEAD_WRAP;
            end else begin
                ld = LEAD_FIRST;
            end
            send_sector(ty, lba0, nsec, sg, ld);
            at_boundary = 1;
            s++;
        end
        drain();

        $display("Streamed %0d sector bytes in %0d scans; %0d partition records checked.",
                 bytes_taken, closes_seen, parts_seen);
        $display("Closing status: ok %0d, no signature %0d, too small %0d, pool full %0d.",
                 status_seen[mbrps_pkg::ST_OK], status_seen[mbrps_pkg::ST_NO_SIG],
                 status_seen[mbrps_pkg::ST_TOO_SMALL], status_seen[mbrps_pkg::ST_POOL_FULL]);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mbrps_pkg.sv
rtl/core/mbrps_ctrl.sv
rtl/core/mbrps_dpath.sv
rtl/core/mbr_partition_scanner.sv
rtl/core/mbrps_checker.sv
verif/mbr_partition_scanner_tb.sv
